// ===== rtl/core/brc_pkg.sv =====
// shared types and constants of the reference-counted block allocator
// no dependencies; imported by brc_ctrl, brc_datapath and block_refcount_allocator
package brc_pkg;

    // fixed field widths of the ports
    localparam int CMD_W = 2;
    localparam int BLK_W = 12;
    localparam int BC_W  = 13;
    localparam int NC_W  = 16;
    localparam int ST_W  = 2;

    // block count after reset
    localparam logic [BC_W-1:0] BC_RESET = 13'd4096;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEC   = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK          = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_PRESENT = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_SPACE    = 2'd2;
    localparam logic [ST_W-1:0] ST_SATURATED   = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic scan_step;
        logic rmw_check;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic cmd_alloc;
        logic cmd_rmw;
        logic scan_found;
        logic scan_empty;
        logic clear_done;
    } dp_sts_t;

endpackage

// ===== rtl/core/brc_ctrl.sv =====
// control state machine of the block allocator: clearing pass, scan and read-modify-write
// depends on brc_pkg
module brc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  brc_pkg::dp_sts_t  sts,
    output brc_pkg::dp_cmd_t  ctl
);
    import brc_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_READ  = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // commands to the datapath
    always_comb
    begin
        ctl.clr_step  = (state_reg == S_CLEAR);
        ctl.accept    = (state_reg == S_IDLE) && in_valid;
        ctl.scan_step = (state_reg == S_SCAN);
        ctl.rmw_check = (state_reg == S_CHECK);
        ctl.load_out  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (sts.cmd_alloc)
                        state_next = S_SCAN;
                    else if (sts.cmd_rmw)
                        state_next = S_READ;
                    else
                        state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_found || sts.scan_empty)
                    state_next = S_DONE;
            end
            S_READ:
                state_next = S_CHECK;
            S_CHECK:
                state_next = S_DONE;
            S_DONE:
            begin
                if (ctl.load_out)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

    // output word valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (ctl.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/brc_datapath.sv =====
// datapath of the block allocator: count memory, next-fit pointer, scan and result registers
// depends on brc_pkg
module brc_datapath #(
    parameter int MAX_BLOCKS = 4096,
    parameter int COUNT_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [brc_pkg::BC_W-1:0]    cfg_data,
    input  logic [brc_pkg::CMD_W-1:0]   command,
    input  logic [brc_pkg::BLK_W-1:0]   block_number,
    input  brc_pkg::dp_cmd_t            ctl,
    output brc_pkg::dp_sts_t            sts,
    output logic [brc_pkg::ST_W-1:0]    status,
    output logic [brc_pkg::BLK_W-1:0]   granted_block,
    output logic [brc_pkg::NC_W-1:0]    new_count,
    output logic                        block_freed
);
    import brc_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int W     = (CNT_W > BC_W) ? CNT_W : BC_W;
    localparam int CW    = (COUNT_BITS > NC_W) ? COUNT_BITS : NC_W;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    // count memory
    logic [COUNT_BITS-1:0] mem [MAX_BLOCKS];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]      mem_raddr;
    logic [IDX_W-1:0]      mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  mem_we;

    // state
    logic [BC_W-1:0]   bc_reg;
    logic [IDX_W-1:0]  ptr_reg;
    logic [IDX_W-1:0]  clr_idx_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [IDX_W-1:0]  blk_reg;
    logic [IDX_W-1:0]  addr_reg;
    logic [IDX_W-1:0]  chk_addr_reg;
    logic [CNT_W-1:0]  issued_reg;
    logic              chk_valid_reg;

    // result and output word
    logic [ST_W-1:0]       res_status_reg;
    logic [IDX_W-1:0]      res_granted_reg;
    logic [COUNT_BITS-1:0] res_count_reg;
    logic                  res_freed_reg;
    logic [ST_W-1:0]       out_status_reg;
    logic [BLK_W-1:0]      out_granted_reg;
    logic [NC_W-1:0]       out_count_reg;
    logic                  out_freed_reg;

    logic [W-1:0]          bc_w;
    logic [W-1:0]          n_w;
    logic [CNT_W-1:0]      n;
    logic [W-1:0]          in_blk_w;
    logic [IDX_W-1:0]      head;
    logic [CNT_W-1:0]      addr_inc;
    logic [IDX_W-1:0]      addr_wrap;
    logic [CNT_W-1:0]      chk_inc;
    logic [IDX_W-1:0]      chk_wrap;
    logic                  more_to_read;
    logic                  scan_hit;
    logic                  c_zero;
    logic                  inc_sat;
    logic [COUNT_BITS-1:0] c_inc;
    logic [COUNT_BITS-1:0] c_dec;
    logic                  rmw_we;

    // effective block count, clamped to 1..MAX_BLOCKS
    always_comb
    begin
        bc_w = W'(bc_reg);
        if (bc_w == '0)
            n_w = W'(1);
        else if (bc_w > W'(MAX_BLOCKS))
            n_w = W'(MAX_BLOCKS);
        else
            n_w = bc_w;
        n = n_w[CNT_W-1:0];
    end

    // classify the incoming word
    assign in_blk_w = W'(block_number);
    always_comb
    begin
        sts.cmd_alloc  = (command == CMD_ALLOC);
        sts.cmd_rmw    = ((command == CMD_INC) || (command == CMD_DEC)) && (in_blk_w < n_w);
        sts.scan_found = scan_hit;
        sts.scan_empty = !chk_valid_reg && !more_to_read;
        sts.clear_done = (clr_idx_reg == IDX_W'(MAX_BLOCKS - 1));
    end

    // scan start and address wrap
    assign head      = (CNT_W'(ptr_reg) >= n) ? '0 : ptr_reg;
    assign addr_inc  = CNT_W'(addr_reg) + CNT_W'(1);
    assign addr_wrap = (addr_inc == n) ? '0 : addr_inc[IDX_W-1:0];
    assign chk_inc   = CNT_W'(chk_addr_reg) + CNT_W'(1);
    assign chk_wrap  = (chk_inc == n) ? '0 : chk_inc[IDX_W-1:0];
    assign more_to_read = (issued_reg < n);
    assign scan_hit  = chk_valid_reg && (rd_data_reg == '0);

    // read-modify-write arithmetic
    assign c_zero  = (rd_data_reg == '0);
    assign inc_sat = (rd_data_reg == CMAX);
    assign c_inc   = rd_data_reg + COUNT_BITS'(1);
    assign c_dec   = rd_data_reg - COUNT_BITS'(1);
    assign rmw_we  = ctl.rmw_check && !c_zero && !((cmd_reg == CMD_INC) && inc_sat);

    // memory port selection
    always_comb
    begin
        mem_raddr = ctl.scan_step ? addr_reg : blk_reg;
        mem_we    = 1'b0;
        mem_waddr = blk_reg;
        mem_wdata = (cmd_reg == CMD_INC) ? c_inc : c_dec;
        if (ctl.clr_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else if (ctl.scan_step && scan_hit)
        begin
            mem_we    = 1'b1;
            mem_waddr = chk_addr_reg;
            mem_wdata = COUNT_BITS'(1);
        end
        else if (rmw_we)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // config, pointer, clearing index and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg        <= BC_RESET;
            ptr_reg       <= '0;
            clr_idx_reg   <= '0;
            chk_valid_reg <= 1'b0;
            issued_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                bc_reg <= cfg_data;
            if (ctl.clr_step)
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            if (ctl.accept)
            begin
                chk_valid_reg <= 1'b0;
                issued_reg    <= '0;
            end
            else if (ctl.scan_step)
            begin
                chk_valid_reg <= more_to_read;
                if (more_to_read)
                    issued_reg <= issued_reg + CNT_W'(1);
            end
            if (ctl.scan_step && scan_hit)
                ptr_reg <= chk_wrap;
        end
    end

    // operation payload and result registers
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg         <= command;
            blk_reg         <= in_blk_w[IDX_W-1:0];
            addr_reg        <= head;
            res_status_reg  <= ST_NOT_PRESENT;
            res_granted_reg <= '0;
            res_count_reg   <= '0;
            res_freed_reg   <= 1'b0;
        end
        if (ctl.scan_step)
        begin
            if (more_to_read)
            begin
                addr_reg     <= addr_wrap;
                chk_addr_reg <= addr_reg;
            end
            if (scan_hit)
            begin
                res_status_reg  <= ST_OK;
                res_granted_reg <= chk_addr_reg;
                res_count_reg   <= COUNT_BITS'(1);
            end
            else if (!chk_valid_reg && !more_to_read)
            begin
                res_status_reg <= ST_NO_SPACE;
            end
        end
        if (ctl.rmw_check && !c_zero)
        begin
            if (cmd_reg == CMD_INC)
            begin
                if (inc_sat)
                begin
                    res_status_reg <= ST_SATURATED;
                    res_count_reg  <= CMAX;
                end
                else
                begin
                    res_status_reg <= ST_OK;
                    res_count_reg  <= c_inc;
                end
            end
            else
            begin
                res_status_reg <= ST_OK;
                res_count_reg  <= c_dec;
                res_freed_reg  <= (c_dec == '0);
            end
        end
        if (ctl.load_out)
        begin
            out_status_reg  <= res_status_reg;
            out_granted_reg <= BLK_W'(res_granted_reg);
            out_count_reg   <= NC_W'(CW'(res_count_reg));
            out_freed_reg   <= res_freed_reg;
        end
    end

    assign status        = out_status_reg;
    assign granted_block = out_granted_reg;
    assign new_count     = out_count_reg;
    assign block_freed   = out_freed_reg;

endmodule

// ===== rtl/core/block_refcount_allocator.sv =====
// top level of the reference-counted next-fit block allocator
// depends on brc_pkg, brc_ctrl and brc_datapath
//
// Keeps a reference count per block in a memory with one read port and one write port;
// a count of zero means free. After reset the block runs a clearing pass, one entry per
// cycle, and holds in_stall high until it ends (block_count writes are taken during it).
// Increment and decrement are a read-modify-write of the count memory: the count is read,
// then checked and written back, and the result word is loaded after that. Allocate
// scans next-fit from the rotating pointer with one memory read per cycle, examining at
// most as many entries as the effective block count. Unknown commands and out-of-range
// blocks go from idle straight to the result load. A result word still waiting in the
// output register holds the load back. One word is worked on at a time; the next input
// word is taken once the result sits in the output register, which holds it until the
// consumer takes it.
module block_refcount_allocator #(
    parameter int MAX_BLOCKS = 4096,
    parameter int COUNT_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [brc_pkg::CMD_W-1:0]   command,
    input  logic [brc_pkg::BLK_W-1:0]   block_number,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [brc_pkg::ST_W-1:0]    status,
    output logic [brc_pkg::BLK_W-1:0]   granted_block,
    output logic [brc_pkg::NC_W-1:0]    new_count,
    output logic                        block_freed,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [brc_pkg::BC_W-1:0]    block_count
);
    import brc_pkg::*;

    dp_cmd_t ctl;
    dp_sts_t sts;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    // controller
    brc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // datapath
    brc_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (block_count),
        .command       (command),
        .block_number  (block_number),
        .ctl           (ctl),
        .sts           (sts),
        .status        (status),
        .granted_block (granted_block),
        .new_count     (new_count),
        .block_freed   (block_freed)
    );

    // no word is taken while the count memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr_step |-> in_stall)
        else $error("input word taken during clearing pass");

    // a freed block always reports ok with a zero count
    a_freed_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_freed |-> (status == ST_OK) && (new_count == '0))
        else $error("freed flag with inconsistent status or count");

    // not-present and no-space results carry all-zero payload
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == ST_NOT_PRESENT) || (status == ST_NO_SPACE))
        |-> (new_count == '0) && (granted_block == '0) && !block_freed)
        else $error("failed operation with nonzero payload");

    // the output word is loaded only when the output register is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |-> (!out_valid || !out_stall))
        else $error("output word overwritten before it was taken");

endmodule
